// ----- rtl/top_two_pairing_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Top-two pairing scheduler assertion macros
// Shared assertion forms for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_TWO_PAIRING_SCHEDULER_DEFINES_SVH
`define TOP_TWO_PAIRING_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// Types and constants of the top-two pairing scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int SLOTS      = 256;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W     = 8;
  localparam int VALUE_W    = 16;
  localparam int PAIR_BITS  = 23;

  localparam logic [PAIR_BITS-1:0] PAIR_MAX = {PAIR_BITS{1'b1}};
  localparam logic [ADDR_BITS-1:0] LAST_IDX = ADDR_BITS'(SLOTS - 1);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PAIR  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRA,
    ST_WRB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] count_value;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    first_slot;
    logic [SLOT_W-1:0]    second_slot;
    logic                 done_res;
    logic [PAIR_BITS-1:0] pairs_emitted;
  } res_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic                  has1;
    logic                  has2;
    logic [ADDR_BITS-1:0]  slot1;
    logic [COUNT_BITS-1:0] cnt1;
    logic [ADDR_BITS-1:0]  slot2;
    logic [COUNT_BITS-1:0] cnt2;
  } top2_t;

endpackage

`default_nettype wire

// ----- rtl/top_two_pairing_scheduler.sv -----
// ----------------------------------------------------------------------------
// top_two_pairing_scheduler
// Per-slot count table with top-two pair selection.
// ----------------------------------------------------------------------------
// Loads, clears and unused request codes return nothing.
// A pair request runs a scan, a drain cycle, two decrement writes (skipped
// when no pair is found) and the result load, which waits while the result
// register is still held by res_stall: the table has a single read port,
// so the scan reads one slot per cycle into a shared compare unit.
// req_stall is high for the whole request. The table needs no
// clearing pass after reset.
`default_nettype none

`include "top_two_pairing_scheduler_defines.svh"

module top_two_pairing_scheduler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tps_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_stall,
  output tps_pkg::res_t      res
);
  import tps_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [ADDR_BITS-1:0]  idx;
  logic [ADDR_BITS-1:0]  idx_next;
  logic [PAIR_BITS-1:0]  pair_counter;
  logic                  out_free;
  logic                  tbl_clr;
  logic                  pick_clr;
  logic                  rd_en;
  logic                  rd_vld;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [ADDR_BITS-1:0]  rd_slot;
  logic                  pair_ok;
  tbl_wr_t               wr;
  top2_t                 best;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = (state != ST_IDLE);
  assign pair_ok   = best.has1 && best.has2;

  tps_table u_table (
    .clk     (clk),
    .rst     (rst),
    .clr     (tbl_clr),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_vld  (rd_vld),
    .rd_cnt  (rd_cnt)
  );

  tps_pick u_pick (
    .clk     (clk),
    .rst     (rst),
    .clr     (pick_clr),
    .in_vld  (rd_vld),
    .in_slot (rd_slot),
    .in_cnt  (rd_cnt),
    .best    (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // slot number of the table word now on the read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= idx;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rd_en      = 1'b0;
    tbl_clr    = 1'b0;
    pick_clr   = 1'b0;
    wr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.req_type)
            REQ_LOAD: begin
              if (32'(req.slot) < SLOTS) begin
                wr.en   = 1'b1;
                wr.addr = ADDR_BITS'(req.slot);
                wr.data = COUNT_BITS'(req.count_value);
              end
            end
            REQ_CLEAR: begin
              tbl_clr = 1'b1;
            end
            REQ_PAIR: begin
              pick_clr   = 1'b1;
              idx_next   = '0;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_LAST;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_LAST: begin
        state_next = ST_WRA;
      end
      ST_WRA: begin
        if (pair_ok) begin
          wr.en      = 1'b1;
          wr.addr    = best.slot1;
          wr.data    = best.cnt1 - 1'b1;
          state_next = ST_WRB;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_WRB: begin
        wr.en      = 1'b1;
        wr.addr    = best.slot2;
        wr.data    = best.cnt2 - 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || tbl_clr) begin
      pair_counter <= '0;
    end else if ((state == ST_WRB) && (pair_counter != PAIR_MAX)) begin
      pair_counter <= pair_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      res.pairs_emitted <= pair_counter;
      if (pair_ok) begin
        res.first_slot  <= SLOT_W'(best.slot1);
        res.second_slot <= SLOT_W'(best.slot2);
        res.done_res    <= 1'b0;
      end else begin
        res.first_slot  <= '0;
        res.second_slot <= '0;
        res.done_res    <= 1'b1;
      end
    end
  end

  `TPS_ASSERT_NOW(a_wrb_pair, state == ST_WRB, pair_ok, "decrement without a pair")
  `TPS_ASSERT_NOW(a_done, res_valid & res.done_res, ~|(res.first_slot | res.second_slot), "slots set")
  `TPS_ASSERT_NOW(a_pair_ne, res_valid & ~res.done_res, res.first_slot != res.second_slot, "slot twice")
  `TPS_ASSERT_NEXT(a_scan_end, state == ST_SCAN && idx == LAST_IDX, state == ST_LAST, "scan overran")

endmodule

`default_nettype wire

// ----- rtl/tps_table.sv -----
// ----------------------------------------------------------------------------
// tps_table
// Count table: one write port, one registered read port, per-entry valid
// bits so reset and clear take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clr,
  input  wire tps_pkg::tbl_wr_t              wr,
  input  wire logic                          rd_en,
  input  wire logic [tps_pkg::ADDR_BITS-1:0] rd_addr,
  output logic                               rd_vld,
  output logic [tps_pkg::COUNT_BITS-1:0]     rd_cnt
);
  import tps_pkg::*;

  logic [COUNT_BITS-1:0] mem [SLOTS];
  logic [SLOTS-1:0]      vbits;
  logic [COUNT_BITS-1:0] data_q;
  logic                  vq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (clr) begin
        vbits <= '0;
      end else if (wr.en) begin
        vbits[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
      vq     <= vbits[rd_addr];
    end
  end

  assign rd_cnt = vq ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/tps_pick.sv -----
// ----------------------------------------------------------------------------
// tps_pick
// Shared compare unit: folds one (slot, count) per cycle into a running
// top-two, ordered by count then by slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_pick (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clr,
  input  wire logic                          in_vld,
  input  wire logic [tps_pkg::ADDR_BITS-1:0] in_slot,
  input  wire logic [tps_pkg::COUNT_BITS-1:0] in_cnt,
  output tps_pkg::top2_t                     best
);
  import tps_pkg::*;

  logic take1;
  logic take2;

  // slots arrive in ascending order, so >= lets the higher slot win ties
  always_comb begin
    take1 = 1'b0;
    take2 = 1'b0;
    if (in_vld && (in_cnt != '0)) begin
      priority if (!best.has1 || (in_cnt >= best.cnt1)) begin
        take1 = 1'b1;
      end else if (!best.has2 || (in_cnt >= best.cnt2)) begin
        take2 = 1'b1;
      end else begin
        take2 = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      best.has1 <= 1'b0;
      best.has2 <= 1'b0;
    end else if (take1) begin
      best.has1  <= 1'b1;
      best.has2  <= best.has1;
      best.slot2 <= best.slot1;
      best.cnt2  <= best.cnt1;
      best.slot1 <= in_slot;
      best.cnt1  <= in_cnt;
    end else if (take2) begin
      best.has2  <= 1'b1;
      best.slot2 <= in_slot;
      best.cnt2  <= in_cnt;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top_two_pairing_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_top_two_pairing_scheduler
// Self-checking bench for the top-two pairing scheduler. A short table of
// loads, clears, ignored codes and pair requests runs first, then a long
// random mix biased toward few busy slots and small counts, so that ties
// and slots draining to zero are common. Every pair result is predicted by
// a local copy of the count table or given in its directed row, and checked
// field by field, in order, while both sides idle and stall in several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top_two_pairing_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import tps_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 850;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    req_t item;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  logic [COUNT_BITS-1:0] count_tbl [SLOTS];
  logic [PAIR_BITS-1:0]  pair_cnt;
  res_t                  pending_pairs [$];
  dir_row_t              dir_tbl [$];

  int  errors = 0;
  int  sent_cnt = 0;
  int  cycle_cnt = 0;
  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  logic hold_off = 1'b0;

  top_two_pairing_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // highest (count, slot) among nonzero slots, -1 when none
  function automatic int pick_top(int skip);
    int best;
    logic [COUNT_BITS-1:0] best_cnt;
    best = -1;
    best_cnt = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (s != skip && count_tbl[s] != '0 && (best < 0 || count_tbl[s] >= best_cnt)) begin
        best = s;
        best_cnt = count_tbl[s];
      end
    end
    return best;
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < SLOTS; s++) count_tbl[s] = '0;
    pair_cnt = '0;
  endfunction

  function automatic bit schedule_pair(input req_t it, output res_t r);
    int a;
    int b;
    r = '0;
    if (it.req_type == REQ_LOAD) begin
      if (int'(it.slot) < SLOTS) count_tbl[it.slot] = COUNT_BITS'(it.count_value);
      return 1'b0;
    end
    if (it.req_type == REQ_CLEAR) begin
      clear_table();
      return 1'b0;
    end
    if (it.req_type != REQ_PAIR) return 1'b0;
    a = pick_top(-1);
    b = (a >= 0) ? pick_top(a) : -1;
    if (a < 0 || b < 0) begin
      r.done_res = 1'b1;
      r.pairs_emitted = pair_cnt;
      return 1'b1;
    end
    count_tbl[a] = count_tbl[a] - 1'b1;
    count_tbl[b] = count_tbl[b] - 1'b1;
    if (pair_cnt != PAIR_MAX) pair_cnt = pair_cnt + 1'b1;
    r.first_slot = SLOT_W'(a);
    r.second_slot = SLOT_W'(b);
    r.pairs_emitted = pair_cnt;
    return 1'b1;
  endfunction

  function automatic dir_row_t row(logic [1:0] op, int s, int v, bit typed = 1'b0,
                                   int f = 0, int sec = 0, bit dn = 1'b0, int pc = 0);
    dir_row_t d;
    d.item.req_type = op;
    d.item.slot = SLOT_W'(s);
    d.item.count_value = VALUE_W'(v);
    d.typed = typed;
    d.want.first_slot = SLOT_W'(f);
    d.want.second_slot = SLOT_W'(sec);
    d.want.done_res = dn;
    d.want.pairs_emitted = PAIR_BITS'(pc);
    return d;
  endfunction

  function automatic void add_row(dir_row_t d);
    dir_tbl.insert(dir_tbl.size(), d);
  endfunction

  function automatic req_t rand_item();
    req_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.slot = SLOT_W'($urandom);
    it.count_value = VALUE_W'($urandom);
    if (pick < 45) begin
      it.req_type = REQ_LOAD;
      pick = $urandom_range(0, 99);
      if (pick < 60) it.slot = SLOT_W'($urandom_range(0, 7));
      else if (pick < 75) it.slot = SLOT_W'($urandom_range(248, 255));
      pick = $urandom_range(0, 99);
      if (pick < 60) it.count_value = VALUE_W'($urandom_range(0, 4));
      else if (pick < 85) it.count_value = VALUE_W'($urandom_range(0, 255));
    end else if (pick < 90) begin
      it.req_type = REQ_PAIR;
    end else if (pick < 93) begin
      it.req_type = REQ_CLEAR;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(req_t it, bit typed, res_t want);
    res_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (schedule_pair(it, r)) pending_pairs.insert(pending_pairs.size(), typed ? want : r);
    sent_cnt++;
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (pending_pairs.size() == 0) begin
      $error("unexpected result transaction: %p", got);
      errors++;
    end else begin
      want = pending_pairs.pop_front();
      if (got.first_slot !== want.first_slot) begin
        $error("first_slot: expected %0d, got %0d", want.first_slot, got.first_slot);
        errors++;
      end
      if (got.second_slot !== want.second_slot) begin
        $error("second_slot: expected %0d, got %0d", want.second_slot, got.second_slot);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        errors++;
      end
      if (got.pairs_emitted !== want.pairs_emitted) begin
        $error("pairs_emitted: expected %0d, got %0d", want.pairs_emitted,
               got.pairs_emitted);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) check_result(res);
      res_stall <= hold_off || ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (sent_cnt >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("top_two_pairing_scheduler regression: fail");
      $finish;
    end
  end

  initial begin
    int   counted;
    int   ph;
    req_t it;
    clear_table();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_row(row(REQ_PAIR, 0, 0, 1'b1, 0, 0, 1'b1, 0));
    add_row(row(REQ_LOAD, 0, 'hFFFF));
    add_row(row(REQ_PAIR, 0, 0, 1'b1, 0, 0, 1'b1, 0));
    add_row(row(REQ_LOAD, 255, 'hFFFF));
    add_row(row(REQ_PAIR, 0, 0, 1'b1, 255, 0, 1'b0, 1));
    add_row(row(REQ_LOAD, 128, 'hFFFF));
    add_row(row(REQ_PAIR, 0, 0));
    add_row(row(REQ_LOAD, 128, 0));
    add_row(row(REQ_PAIR, 'hFF, 'hFFFF));
    add_row(row(REQ_UNUSED, 'hFF, 'hFFFF));
    add_row(row(REQ_LOAD, 'h55, 'hAAAA));
    add_row(row(REQ_LOAD, 'hAA, 'h5555));
    add_row(row(REQ_PAIR, 0, 0));
    add_row(row(REQ_CLEAR, 'hAA, 'h5555));
    add_row(row(REQ_PAIR, 0, 0, 1'b1, 0, 0, 1'b1, 0));
    add_row(row(REQ_LOAD, 1, 1));
    add_row(row(REQ_LOAD, 2, 1));
    add_row(row(REQ_PAIR, 0, 0, 1'b1, 2, 1, 1'b0, 1));
    add_row(row(REQ_PAIR, 0, 0, 1'b1, 0, 0, 1'b1, 1));
    add_row(row(REQ_LOAD, 'h7F, 2));
    add_row(row(REQ_LOAD, 'h80, 2));
    add_row(row(REQ_LOAD, 'h40, 2));
    add_row(row(REQ_PAIR, 0, 0));
    add_row(row(REQ_PAIR, 0, 0));
    add_row(row(REQ_PAIR, 0, 0));

    foreach (dir_tbl[i]) send_item(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);

    counted = 0;
    while (counted < RAND_ITEMS) begin
      ph = (counted / 100) % 5;
      snd_idle_pct <= (ph == 1) ? 54 : (ph == 3) ? 18 : 0;
      rcv_stall_pct <= (ph == 2) ? 54 : (ph == 3) ? 18 : 0;
      it = rand_item();
      send_item(it, 1'b0, '0);
      counted++;
    end
    req_valid <= 1'b0;

    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("top_two_pairing_scheduler regression: pass");
    end else begin
      $display("top_two_pairing_scheduler regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
